// ----- src/dfhe_pkg.sv -----
// ============================================================================
// Fixed Huffman deflate encoder package
// Shared types, code tables and helper functions for the encoder blocks.
// ============================================================================
package dfhe_pkg;

    localparam int DFHE_QDEPTH = 2;   // default depth of the token queue
    localparam int ACC_W       = 48;  // pending bit store
    localparam int CNT_W       = 6;   // pending bit count
    localparam int CHUNK_W     = 34;  // header + length code + extras + distance

    typedef struct packed {
        logic [7:0]  literal_byte;
        logic [8:0]  match_length;
        logic [15:0] match_distance;
        logic        final_block;
        logic        last_token;
    } t_token;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       block_done;
    } t_result;

    // One token after classification, with every code already in stream order.
    typedef struct packed {
        logic        hdr;
        logic        fin;
        logic        is_match;
        logic        last;
        logic [8:0]  code;
        logic [3:0]  code_len;
        logic [4:0]  ext;
        logic [2:0]  ext_len;
        logic [4:0]  dcode;
        logic [12:0] dext;
        logic [3:0]  dext_len;
    } t_cls;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             flush;
    } t_back_stat;

    localparam logic [8:0] LEN_BASE [29] = '{
        9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15,
        9'd17, 9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67,
        9'd83, 9'd99, 9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
    };
    localparam logic [2:0] LEN_EXTRA [29] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4,
        3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd0
    };
    localparam logic [15:0] DIST_BASE [30] = '{
        16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17,
        16'd25, 16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257,
        16'd385, 16'd513, 16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073,
        16'd4097, 16'd6145, 16'd8193, 16'd12289, 16'd16385, 16'd24577
    };
    localparam logic [3:0] DIST_EXTRA [30] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3,
        4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8,
        4'd9, 4'd9, 4'd10, 4'd10, 4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
    };

    function automatic logic [4:0] len_index(input logic [8:0] len);
        logic [4:0] c;
        c = '0;
        for (int i = 0; i < 29; i++) begin
            if (LEN_BASE[i] <= len) begin
                c = 5'(i);
            end
        end
        return c;
    endfunction

    function automatic logic [4:0] dist_index(input logic [15:0] distance);
        logic [4:0] c;
        c = '0;
        for (int i = 0; i < 30; i++) begin
            if (DIST_BASE[i] <= distance) begin
                c = 5'(i);
            end
        end
        return c;
    endfunction

    // Huffman codes go out most significant bit first, so they are mirrored.
    function automatic logic [8:0] rev_code(input logic [8:0] v, input logic [3:0] n);
        logic [8:0] r;
        r = '0;
        case (n)
            4'd7: begin
                for (int i = 0; i < 7; i++) r[i] = v[6-i];
            end
            4'd8: begin
                for (int i = 0; i < 8; i++) r[i] = v[7-i];
            end
            default: begin
                for (int i = 0; i < 9; i++) r[i] = v[8-i];
            end
        endcase
        return r;
    endfunction

    function automatic logic [4:0] rev5(input logic [4:0] v);
        logic [4:0] r;
        for (int i = 0; i < 5; i++) r[i] = v[4-i];
        return r;
    endfunction

endpackage

// ----- src/dfhe_front.sv -----
// ============================================================================
// Token classifier
// Maps one token to its length, distance or literal code and extra bits,
// and tracks whether the block header is still owed.
// ============================================================================
module dfhe_front import dfhe_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_accept,
    input  t_token i_token,
    output t_cls   o_cls
);

    logic        r_in_block;
    logic        n_in_block;
    logic [8:0]  len_sat;
    logic [15:0] dist_sat;
    logic [4:0]  lc;
    logic [4:0]  dc;
    logic [8:0]  ldiff;
    logic [15:0] ddiff;
    logic [8:0]  code_raw;
    logic [3:0]  code_len;
    logic        is_match;

    always_comb begin
        is_match = i_token.match_length > 9'd1;

        if (i_token.match_length < 9'd3) begin
            len_sat = 9'd3;
        end else if (i_token.match_length > 9'd258) begin
            len_sat = 9'd258;
        end else begin
            len_sat = i_token.match_length;
        end

        if (i_token.match_distance == 16'd0) begin
            dist_sat = 16'd1;
        end else if (i_token.match_distance > 16'd32768) begin
            dist_sat = 16'd32768;
        end else begin
            dist_sat = i_token.match_distance;
        end

        lc    = len_index(len_sat);
        dc    = dist_index(dist_sat);
        ldiff = len_sat - LEN_BASE[lc];
        ddiff = dist_sat - DIST_BASE[dc];

        // Length symbols 257..279 have 7-bit codes, 280..285 have 8-bit codes.
        if (is_match) begin
            if (lc <= 5'd22) begin
                code_raw = {4'd0, lc} + 9'd1;
                code_len = 4'd7;
            end else begin
                code_raw = {4'd0, lc} + 9'd169;
                code_len = 4'd8;
            end
        end else if (i_token.literal_byte < 8'd144) begin
            code_raw = {1'b0, i_token.literal_byte} + 9'h030;
            code_len = 4'd8;
        end else begin
            code_raw = {1'b0, i_token.literal_byte} + 9'd256;
            code_len = 4'd9;
        end

        o_cls.hdr      = !r_in_block;
        o_cls.fin      = i_token.final_block;
        o_cls.is_match = is_match;
        o_cls.last     = i_token.last_token;
        o_cls.code     = rev_code(code_raw, code_len);
        o_cls.code_len = code_len;
        o_cls.ext      = is_match ? ldiff[4:0] : 5'd0;
        o_cls.ext_len  = is_match ? LEN_EXTRA[lc] : 3'd0;
        o_cls.dcode    = rev5(dc);
        o_cls.dext     = is_match ? ddiff[12:0] : 13'd0;
        o_cls.dext_len = is_match ? DIST_EXTRA[dc] : 4'd0;

        n_in_block = i_accept ? !i_token.last_token : r_in_block;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_block <= 1'b0;
        end else begin
            r_in_block <= n_in_block;
        end
    end

endmodule

// ----- src/dfhe_queue.sv -----
// ============================================================================
// Token queue
// Short first-in first-out store between the classifier and the bit packer.
// ============================================================================
module dfhe_queue import dfhe_pkg::*; #(
    parameter int DEPTH = DFHE_QDEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cls i_wdata,
    output logic o_full,
    input  logic i_rd,
    output t_cls o_rdata,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls          r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wp;
    logic [PW-1:0] n_rp;
    logic [CW-1:0] n_count;

    always_comb begin
        o_full  = r_count == CW'(DEPTH);
        o_empty = r_count == '0;
        o_rdata = r_mem[r_rp];

        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_wr) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_rd) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

// ----- src/dfhe_back.sv -----
// ============================================================================
// Bit packer
// Builds each token's bit string, merges it into the pending bits and
// hands out whole bytes, one per cycle while popped, via an output register.
// ============================================================================
module dfhe_back import dfhe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cls_valid,
    input  t_cls       i_cls,
    output logic       o_cls_take,
    output t_result    o_result,
    output logic       o_empty,
    input  logic       i_pop,
    output t_back_stat o_stat
);

    // Build stage
    logic               r_bv;
    logic [CHUNK_W-1:0] r_chunk;
    logic [CNT_W-1:0]   r_bn;
    logic               r_blast;
    logic [CHUNK_W-1:0] b_chunk;
    logic [CNT_W-1:0]   p1;
    logic [CNT_W-1:0]   p2;
    logic [CNT_W-1:0]   p3;
    logic [CNT_W-1:0]   p4;

    // Pack stage
    logic [ACC_W-1:0]   r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_flush;
    logic               r_ov;
    t_result            r_out;
    logic [ACC_W-1:0]   n_acc;
    logic [CNT_W-1:0]   n_cnt;
    logic               n_flush;
    logic [ACC_W-1:0]   acc_a;
    logic [CNT_W-1:0]   cnt_a;
    logic [CNT_W-1:0]   sum;
    logic [CNT_W-1:0]   padded;
    logic               emit;
    logic               merge;

    always_comb begin
        b_chunk = '0;
        if (i_cls.hdr) begin
            b_chunk[2:0] = {1'b0, 1'b1, i_cls.fin};
        end
        p1 = (i_cls.hdr ? CNT_W'(3) : CNT_W'(0));
        b_chunk = b_chunk | (CHUNK_W'(i_cls.code) << p1);
        p2 = p1 + CNT_W'(i_cls.code_len);
        if (i_cls.is_match) begin
            b_chunk = b_chunk | (CHUNK_W'(i_cls.ext) << p2);
            p3 = p2 + CNT_W'(i_cls.ext_len);
            b_chunk = b_chunk | (CHUNK_W'(i_cls.dcode) << p3);
            p3 = p3 + CNT_W'(5);
            b_chunk = b_chunk | (CHUNK_W'(i_cls.dext) << p3);
            p4 = p3 + CNT_W'(i_cls.dext_len);
        end else begin
            p3 = p2;
            p4 = p2;
        end
    end

    always_comb begin
        emit  = (r_cnt >= CNT_W'(8)) && (!r_ov || i_pop);
        acc_a = emit ? (r_acc >> 8) : r_acc;
        cnt_a = emit ? (r_cnt - CNT_W'(8)) : r_cnt;

        // A new token joins only when no whole byte is left behind.
        merge      = r_bv && (cnt_a < CNT_W'(8));
        o_cls_take = i_cls_valid && (!r_bv || merge);

        // The end-of-block code is seven zero bits, then zero padding.
        sum    = cnt_a + r_bn;
        padded = sum + CNT_W'(14);

        n_acc   = acc_a;
        n_cnt   = cnt_a;
        n_flush = r_flush;
        if (emit && (r_cnt == CNT_W'(8))) begin
            n_flush = 1'b0;
        end
        if (merge) begin
            n_acc = acc_a | (ACC_W'(r_chunk) << cnt_a[2:0]);
            if (r_blast) begin
                n_cnt   = {padded[CNT_W-1:3], 3'b000};
                n_flush = 1'b1;
            end else begin
                n_cnt = sum;
            end
        end

        o_result     = r_out;
        o_empty      = !r_ov;
        o_stat.cnt   = r_cnt;
        o_stat.flush = r_flush;
    end

    always_ff @(posedge i_clk) begin
        if (o_cls_take) begin
            r_chunk <= b_chunk;
            r_bn    <= p4;
            r_blast <= i_cls.last;
        end
        if (emit) begin
            r_out.out_byte   <= r_acc[7:0];
            r_out.block_done <= r_flush && (r_cnt == CNT_W'(8));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv    <= 1'b0;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_flush <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (o_cls_take) begin
                r_bv <= 1'b1;
            end else if (merge) begin
                r_bv <= 1'b0;
            end
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_flush <= n_flush;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

// ----- src/deflate_fixed_huffman_encoder.sv -----
// ============================================================================
// Fixed Huffman deflate encoder
// Turns LZ77 tokens into a byte stream of deflate blocks with fixed codes.
// ============================================================================
// Usage:
//   Tokens enter through a queue-style port: a beat is taken on a clock edge
//   with push high and full low. Bytes leave the same way: while empty is
//   low the oldest byte is on o_result, and it is taken when pop is high.
//   block_done marks the last, zero-padded byte of a block.
//   With the packer idle, a token passes from the queue through the build
//   register and the pending bits into the output register. Throughput: one
//   byte per cycle at the output register while pop stays high; a token
//   joins the pending bits only when no whole byte is left behind. The
//   byte-wide output register sets the byte rate.
//   A two-entry token queue lets new tokens be taken while the packer waits.
//   When the receiver stalls, the packer holds its bits, the queue fills and
//   full rises; nothing is dropped.
//   Reset clears the queue, the pending bits and the header flag, so the
//   next token opens a new block.
// ============================================================================
module deflate_fixed_huffman_encoder import dfhe_pkg::*; #(
    parameter int QUEUE_DEPTH = DFHE_QDEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_token  i_token,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    t_cls       front_cls;
    t_cls       queue_cls;
    logic       queue_empty;
    logic       back_take;
    logic       accept;
    t_back_stat stat;

    assign accept = push && !full;

    dfhe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_token  (i_token),
        .o_cls    (front_cls)
    );

    dfhe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_wdata (front_cls),
        .o_full  (full),
        .i_rd    (back_take),
        .o_rdata (queue_cls),
        .o_empty (queue_empty)
    );

    dfhe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (!queue_empty),
        .i_cls       (queue_cls),
        .o_cls_take  (back_take),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_stat      (stat)
    );

    // The pending bits never outgrow the store.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.cnt <= CNT_W'(48))
        else $error("pending bit count exceeds the bit store");

    // After a block end the pending bits sit on a byte boundary.
    a_flush_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.flush |-> (stat.cnt[2:0] == 3'd0))
        else $error("block end left a partial byte");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !stat.flush && (stat.cnt == '0)))
        else $error("reset did not clear the packer");

endmodule

// ----- test/deflate_fixed_huffman_encoder_tb.sv -----
// ============================================================================
// Testbench for the fixed Huffman deflate encoder
// Drives LZ77 tokens into the encoder and checks every compressed byte.
// Expected bytes come from a bit packer that runs alongside the stimulus.
// The run covers literal and match extremes, saturated lengths and distances,
// and blocks that end on a byte boundary. It also covers a long output stall
// and random blocks under several idle patterns.
// ============================================================================
module deflate_fixed_huffman_encoder_tb;
    import dfhe_pkg::*;

    localparam logic [1:0] BTYPE_FIXED  = 2'b01;
    localparam int         END_OF_BLOCK = 256;
    localparam int         LEN_SYM_BASE = 257;
    localparam int         MAX_BURST    = 6;
    localparam int         HOLD_CYCLES  = 200;
    localparam int         DRAIN_CYCLES = 20;

    localparam int LEN_BASE_TAB [29] = '{
        3, 4, 5, 6, 7, 8, 9, 10, 11, 13, 15, 17, 19, 23, 27, 31,
        35, 43, 51, 59, 67, 83, 99, 115, 131, 163, 195, 227, 258
    };
    localparam int LEN_EXTRA_TAB [29] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2,
        3, 3, 3, 3, 4, 4, 4, 4, 5, 5, 5, 5, 0
    };
    localparam int DIST_BASE_TAB [30] = '{
        1, 2, 3, 4, 5, 7, 9, 13, 17, 25, 33, 49, 65, 97, 129, 193,
        257, 385, 513, 769, 1025, 1537, 2049, 3073, 4097, 6145,
        8193, 12289, 16385, 24577
    };
    localparam int DIST_EXTRA_TAB [30] = '{
        0, 0, 0, 0, 1, 1, 2, 2, 3, 3, 4, 4, 5, 5, 6, 6,
        7, 7, 8, 8, 9, 9, 10, 10, 11, 11, 12, 12, 13, 13
    };

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    push    = 1'b0;
    logic    full;
    t_token  i_token = '0;
    logic    empty;
    logic    pop     = 1'b0;
    t_result o_result;

    // Bit packer state that mirrors the encoder.
    logic [63:0] pend_bits = '0;
    int          pend_cnt  = 0;
    bit          hdr_done  = 1'b0;

    t_result expected_bytes [$];
    int      mismatch_count = 0;
    int      tx_idle_pct    = 0;
    int      rx_idle_pct    = 0;
    logic    hold_rx        = 1'b0;

    deflate_fixed_huffman_encoder uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_token  (i_token),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void append_bits(input logic [31:0] val, input int n);
        logic [63:0] mask;
        mask = (64'd1 << n) - 64'd1;
        pend_bits = pend_bits | (({32'd0, val} & mask) << pend_cnt);
        pend_cnt  = pend_cnt + n;
    endfunction

    // Huffman codes enter the stream most significant bit first.
    function automatic void append_code(input logic [31:0] code, input int n);
        logic [31:0] mirrored;
        mirrored = '0;
        for (int i = 0; i < n; i++) begin
            mirrored[n-1-i] = code[i];
        end
        append_bits(mirrored, n);
    endfunction

    function automatic void append_symbol(input int sym);
        if (sym < 144) begin
            append_code(32'(8'h30 + sym), 8);
        end else if (sym < 256) begin
            append_code(32'(9'h190 + (sym - 144)), 9);
        end else if (sym < 280) begin
            append_code(32'(sym - 256), 7);
        end else begin
            append_code(32'(8'hC0 + (sym - 280)), 8);
        end
    endfunction

    function automatic void encode_token(input t_token tok);
        int      len;
        int      distance;
        int      idx;
        int      n;
        t_result burst [MAX_BURST];
        if (!hdr_done) begin
            append_bits(32'(tok.final_block), 1);
            append_bits(32'(BTYPE_FIXED), 2);
            hdr_done = 1'b1;
        end
        if (tok.match_length > 1) begin
            len      = tok.match_length;
            distance = tok.match_distance;
            if (len < 3) len = 3;
            if (len > 258) len = 258;
            if (distance < 1) distance = 1;
            if (distance > 32768) distance = 32768;
            idx = 0;
            for (int i = 0; i < 29; i++) begin
                if (LEN_BASE_TAB[i] <= len) idx = i;
            end
            append_symbol(LEN_SYM_BASE + idx);
            append_bits(32'(len - LEN_BASE_TAB[idx]), LEN_EXTRA_TAB[idx]);
            idx = 0;
            for (int i = 0; i < 30; i++) begin
                if (DIST_BASE_TAB[i] <= distance) idx = i;
            end
            append_code(32'(idx), 5);
            append_bits(32'(distance - DIST_BASE_TAB[idx]), DIST_EXTRA_TAB[idx]);
        end else begin
            append_symbol(tok.literal_byte);
        end
        if (tok.last_token) begin
            append_symbol(END_OF_BLOCK);
            pend_cnt = (pend_cnt + 7) & ~7;
        end
        n = 0;
        while (pend_cnt >= 8 && n < MAX_BURST) begin
            burst[n].out_byte   = pend_bits[7:0];
            burst[n].block_done = 1'b0;
            pend_bits = pend_bits >> 8;
            pend_cnt  = pend_cnt - 8;
            n++;
        end
        if (tok.last_token) begin
            if (n > 0) burst[n-1].block_done = 1'b1;
            pend_bits = '0;
            pend_cnt  = 0;
            hdr_done  = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            expected_bytes.push_back(burst[i]);
        end
    endfunction

    function automatic t_token make_token(input logic [7:0] lit, input logic [8:0] len,
                                          input logic [15:0] distance, input logic fin,
                                          input logic last);
        t_token tok;
        tok.literal_byte   = lit;
        tok.match_length   = len;
        tok.match_distance = distance;
        tok.final_block    = fin;
        tok.last_token     = last;
        return tok;
    endfunction

    // Mostly well-formed literals and matches, with some out-of-range fields.
    function automatic t_token random_token(input logic last);
        int          kind;
        logic [8:0]  len;
        logic [15:0] distance;
        kind     = $urandom_range(99);
        distance = 16'($urandom_range(65535));
        if (kind < 45) begin
            len = 9'($urandom_range(1));
        end else if (kind < 90) begin
            len      = $urandom_range(1) ? 9'($urandom_range(10, 3))
                                         : 9'($urandom_range(258, 3));
            distance = $urandom_range(1) ? 16'($urandom_range(64, 1))
                                         : 16'($urandom_range(32768, 1));
        end else begin
            case ($urandom_range(2))
                0: len = 9'd2;
                1: len = 9'($urandom_range(511, 259));
                default: len = 9'($urandom_range(258, 3));
            endcase
            distance = $urandom_range(1) ? 16'd0 : 16'($urandom_range(65535, 32769));
        end
        return make_token(8'($urandom_range(255)), len, distance, 1'($urandom_range(1)),
                          last);
    endfunction

    // Push stays high between back-to-back beats; it only drops while idling.
    task automatic send_token(input t_token tok);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        i_token <= tok;
        do @(posedge i_clk); while (full);
        encode_token(tok);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got byte %02h done %0b",
                             $time, o_result.out_byte, o_result.block_done);
                    mismatch_count++;
                end else begin
                    if (o_result.out_byte !== expected_bytes[0].out_byte) begin
                        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                                 $time, expected_bytes[0].out_byte, o_result.out_byte);
                        mismatch_count++;
                    end
                    if (o_result.block_done !== expected_bytes[0].block_done) begin
                        $display("%0t: block_done mismatch, expected %0b, got %0b",
                                 $time, expected_bytes[0].block_done, o_result.block_done);
                        mismatch_count++;
                    end
                    void'(expected_bytes.pop_front());
                end
            end
            pop <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Code boundaries at 143/144 and 255, both no-match lengths, ignored fields.
    task automatic test_literals();
        send_token(make_token(8'd0,   9'd0, 16'd0,     1'b1, 1'b0));
        send_token(make_token(8'd143, 9'd1, 16'd12345, 1'b0, 1'b0));
        send_token(make_token(8'd144, 9'd0, 16'hFFFF,  1'b0, 1'b0));
        send_token(make_token(8'd255, 9'd1, 16'd1,     1'b1, 1'b1));
    endtask

    // Length and distance extremes, including the saturated and clamped values.
    task automatic test_matches();
        send_token(make_token(8'hA5, 9'd3,   16'd1,     1'b0, 1'b0));
        send_token(make_token(8'h5A, 9'd258, 16'd32768, 1'b1, 1'b0));
        send_token(make_token(8'hFF, 9'd2,   16'd0,     1'b0, 1'b0));
        send_token(make_token(8'h00, 9'd259, 16'd32769, 1'b1, 1'b0));
        send_token(make_token(8'h81, 9'd511, 16'd65535, 1'b0, 1'b0));
        send_token(make_token(8'h7E, 9'd10,  16'd24577, 1'b0, 1'b0));
        send_token(make_token(8'h3C, 9'd11,  16'd4,     1'b0, 1'b0));
        send_token(make_token(8'hC3, 9'd227, 16'd5,     1'b1, 1'b1));
    endtask

    // Header, 13-bit match, 9-bit literal and end code fill exactly four bytes.
    task automatic test_aligned_end();
        send_token(make_token(8'h12, 9'd3, 16'd5, 1'b0, 1'b0));
        send_token(make_token(8'd200, 9'd0, 16'd0, 1'b0, 1'b1));
    endtask

    // One-token blocks, the second one producing the longest burst of bytes.
    task automatic test_single_token_blocks();
        send_token(make_token(8'd65, 9'd0, 16'd0, 1'b1, 1'b1));
        send_token(make_token(8'd0, 9'd257, 16'd32768, 1'b0, 1'b1));
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_rx <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
            begin
                for (int k = 0; k < 12; k++) begin
                    send_token(make_token(8'(k), 9'd200, 16'd30000, 1'b0, 1'(k % 4 == 3)));
                end
            end
        join
    endtask

    task automatic test_random_blocks(input int tx_pct, input int rx_pct, input int n_items);
        int   sent;
        int   blk_len;
        sent        = 0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (sent < n_items) begin
            blk_len = $urandom_range(8, 1);
            if (blk_len > n_items - sent) begin
                blk_len = n_items - sent;
            end
            for (int k = 0; k < blk_len; k++) begin
                send_token(random_token(1'(k == blk_len - 1)));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 38;
        rx_idle_pct = 71;
        test_literals();
        test_matches();
        test_aligned_end();
        test_single_token_blocks();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_backpressure();

        test_random_blocks(38, 71, 30);
        test_random_blocks(71, 38, 30);
        test_random_blocks(0, 0, 30);
        push <= 1'b0;

        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("deflate_fixed_huffman_encoder_tb: PASS");
        end else begin
            $display("deflate_fixed_huffman_encoder_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("deflate_fixed_huffman_encoder_tb: FAIL");
        $finish;
    end

endmodule

// ----- deflate_fixed_huffman_encoder.f -----
src/dfhe_pkg.sv
src/dfhe_front.sv
src/dfhe_queue.sv
src/dfhe_back.sv
src/deflate_fixed_huffman_encoder.sv
test/deflate_fixed_huffman_encoder_tb.sv
